// ===== src/rfbfs_pkg.sv =====
package rfbfs_pkg;

    localparam int MAX_REGIONS_DEF = 16;
    localparam int PIXEL_COUNT_BITS_DEF = 23;
    localparam int FRAME_BITS_DEF = 16;
    localparam int PIX_W = 8;
    localparam int RID_W = 4;
    localparam int CFG_W = 5;
    localparam int HW_REGIONS = 16;
    localparam logic [CFG_W-1:0] REGIONS_RESET = 5'd16;
    localparam int MUL_W = 32;
    localparam int OPND_W = 64;
    localparam int PROD_W = 128;
    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP,
        BK_MULA,
        BK_MULB,
        BK_CMP,
        BK_OUT
    } bk_state_t;

    typedef enum logic [1:0] {
        MUL_NQ,
        MUL_SS,
        MUL_NS
    } prep_step_t;

    typedef struct packed {
        logic [RID_W:0]   n_out;
        logic [31:0]      frame;
    } frame_job_t;

endpackage

// ===== src/rfbfs_mul.sv =====
module rfbfs_mul
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [rfbfs_pkg::OPND_W-1:0]    a,
    input  logic [rfbfs_pkg::OPND_W-1:0]    b,
    output logic                            done,
    output logic [rfbfs_pkg::PROD_W-1:0]    product
);

    logic [2:0]                          step_reg;
    logic [2:0]                          step_next;
    logic                                busy_reg;
    logic                                busy_next;
    logic [rfbfs_pkg::OPND_W-1:0]        a_reg;
    logic [rfbfs_pkg::OPND_W-1:0]        b_reg;
    logic [rfbfs_pkg::PROD_W-1:0]        acc_reg;
    logic [rfbfs_pkg::PROD_W-1:0]        acc_next;
    logic [rfbfs_pkg::MUL_W-1:0]         pa;
    logic [rfbfs_pkg::MUL_W-1:0]         pb;
    logic [2*rfbfs_pkg::MUL_W-1:0]       pp_reg;
    logic [1:0]                          sh_reg;
    logic                                pp_vld_reg;

    // partial product selection
    always_comb
    begin
        pa = step_reg[1] ? a_reg[63:32] : a_reg[31:0];
        pb = step_reg[0] ? b_reg[63:32] : b_reg[31:0];
        busy_next = busy_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 3'd0;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            step_next = step_reg + 3'd1;
            if (pp_vld_reg)
            begin
                acc_next = acc_reg + ({64'd0, pp_reg} << (32 * {5'd0, sh_reg}));
            end
            if (step_reg == 3'd4)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            step_reg   <= '0;
            pp_vld_reg <= 1'b0;
            done       <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            step_reg   <= step_next;
            pp_vld_reg <= busy_reg && !start && step_reg < 3'd4;
            done       <= busy_reg && !start && step_reg == 3'd4;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        pp_reg  <= pa * pb;
        sh_reg  <= step_reg[1] + step_reg[0];
        acc_reg <= acc_next;
    end

    assign product = acc_reg;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy_reg))
        else $error("done without busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= 3'd4)
        else $error("step overrun");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held");
`endif

endmodule

// ===== src/rfbfs_front.sv =====
module rfbfs_front
#(
    parameter int MAX_REGIONS      = rfbfs_pkg::MAX_REGIONS_DEF,
    parameter int PIXEL_COUNT_BITS = rfbfs_pkg::PIXEL_COUNT_BITS_DEF,
    parameter int FRAME_BITS       = rfbfs_pkg::FRAME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rfbfs_pkg::PIX_W-1:0]       gray_pixel,
    input  logic [rfbfs_pkg::RID_W-1:0]       region_id,
    input  logic                              in_region,
    input  logic                              end_of_frame,
    input  logic [rfbfs_pkg::CFG_W-1:0]       regions_cfg,
    input  logic                              rd_en,
    input  logic [rfbfs_pkg::RID_W-1:0]       rd_region,
    output logic [PIXEL_COUNT_BITS-1:0]       rd_n,
    output logic [PIXEL_COUNT_BITS+7:0]       rd_s,
    output logic [PIXEL_COUNT_BITS+15:0]      rd_q,
    input  logic                              job_pop,
    output logic                              job_avail,
    output rfbfs_pkg::frame_job_t             job
);

    localparam int NR = (MAX_REGIONS < rfbfs_pkg::HW_REGIONS) ? MAX_REGIONS
                                                              : rfbfs_pkg::HW_REGIONS;
    localparam int BANK_W = 1;
    localparam logic [PIXEL_COUNT_BITS-1:0] CMAX = '1;

    // two banks: one accumulates, the other is drained by the back end
    logic [PIXEL_COUNT_BITS-1:0]  n_reg [2][NR];
    logic [PIXEL_COUNT_BITS+7:0]  s_reg [2][NR];
    logic [PIXEL_COUNT_BITS+15:0] q_reg [2][NR];
    logic [NR-1:0]                clr_reg [2];
    logic [BANK_W-1:0]            wbank_reg;
    logic                         full_reg;
    logic [FRAME_BITS-1:0]        frame_reg;
    rfbfs_pkg::frame_job_t        job_reg;
    logic                         accept;
    logic [rfbfs_pkg::CFG_W-1:0]  nsel;
    logic [rfbfs_pkg::RID_W-1:0]  rid_c;
    logic                         hit;
    logic [PIXEL_COUNT_BITS-1:0]  cur_n;
    logic [rfbfs_pkg::RID_W-1:0]  rd_c;

    assign in_stall  = full_reg && end_of_frame;
    assign accept    = in_valid && !in_stall;
    assign job_avail = full_reg;
    assign job       = job_reg;
    assign rid_c     = region_id;
    assign hit       = in_region && gray_pixel != '0 && 32'(region_id) < NR;
    assign cur_n     = clr_reg[wbank_reg][rid_c] ? n_reg[wbank_reg][rid_c] : '0;
    assign rd_c      = rd_region;

    always_comb
    begin
        nsel = regions_cfg;
        if (nsel == '0)
        begin
            nsel = 5'd1;
        end
        if (32'(nsel) > NR)
        begin
            nsel = rfbfs_pkg::CFG_W'(NR);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wbank_reg  <= '0;
            full_reg   <= 1'b0;
            frame_reg  <= '0;
            clr_reg[0] <= '0;
            clr_reg[1] <= '0;
        end
        else
        begin
            if (accept && hit && cur_n != CMAX)
            begin
                clr_reg[wbank_reg][rid_c] <= 1'b1;
            end
            if (accept && end_of_frame)
            begin
                wbank_reg <= ~wbank_reg;
                full_reg  <= 1'b1;
                frame_reg <= frame_reg + 1'b1;
                clr_reg[~wbank_reg] <= '0;
            end
            else if (job_pop)
            begin
                full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit && cur_n != CMAX)
        begin
            n_reg[wbank_reg][rid_c] <= cur_n + 1'b1;
            s_reg[wbank_reg][rid_c] <= (clr_reg[wbank_reg][rid_c] ?
                s_reg[wbank_reg][rid_c] : '0) + (PIXEL_COUNT_BITS+8)'(gray_pixel);
            q_reg[wbank_reg][rid_c] <= (clr_reg[wbank_reg][rid_c] ?
                q_reg[wbank_reg][rid_c] : '0)
                + (PIXEL_COUNT_BITS+16)'({8'd0, gray_pixel} * {8'd0, gray_pixel});
        end
        if (accept && end_of_frame)
        begin
            job_reg.n_out <= nsel;
            job_reg.frame <= 32'(frame_reg);
        end
        if (rd_en)
        begin
            if (32'(rd_region) < NR && clr_reg[~wbank_reg][rd_c])
            begin
                rd_n <= n_reg[~wbank_reg][rd_c];
                rd_s <= s_reg[~wbank_reg][rd_c];
                rd_q <= q_reg[~wbank_reg][rd_c];
            end
            else
            begin
                rd_n <= '0;
                rd_s <= '0;
                rd_q <= '0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> full_reg)
        else $error("pop of empty bank");
    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_frame) |=> wbank_reg != $past(wbank_reg))
        else $error("bank not swapped");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> full_reg)
        else $error("stall while bank free");
`endif

endmodule

// ===== src/rfbfs_back.sv =====
module rfbfs_back
#(
    parameter int PIXEL_COUNT_BITS = rfbfs_pkg::PIXEL_COUNT_BITS_DEF,
    parameter int FRAME_BITS       = rfbfs_pkg::FRAME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              job_avail,
    input  rfbfs_pkg::frame_job_t             job,
    output logic                              job_pop,
    output logic                              rd_en,
    output logic [rfbfs_pkg::RID_W-1:0]       rd_region,
    input  logic [PIXEL_COUNT_BITS-1:0]       rd_n,
    input  logic [PIXEL_COUNT_BITS+7:0]       rd_s,
    input  logic [PIXEL_COUNT_BITS+15:0]      rd_q,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [rfbfs_pkg::RID_W-1:0]       region_index,
    output logic [15:0]                       best_frame,
    output logic                              best_found,
    output logic                              improved_now,
    output logic                              last_region
);

    localparam int NR = rfbfs_pkg::HW_REGIONS;

    rfbfs_pkg::bk_state_t               st_reg;
    rfbfs_pkg::bk_state_t               st_next;
    rfbfs_pkg::prep_step_t              pst_reg;
    rfbfs_pkg::prep_step_t              pst_next;
    logic                               busy_reg;
    logic                               busy_next;
    logic [rfbfs_pkg::RID_W:0]          r_reg;
    logic [rfbfs_pkg::RID_W:0]          r_next;
    rfbfs_pkg::frame_job_t              cur_reg;
    logic [63:0]                        nq_reg;
    logic [63:0]                        num_reg;
    logic [63:0]                        den_reg;
    logic [127:0]                       lhs_reg;
    logic [61:0]                        bnum_reg [NR];
    logic [2*PIXEL_COUNT_BITS+7:0]      bden_reg [NR];
    logic [FRAME_BITS-1:0]              bfr_reg  [NR];
    logic [NR-1:0]                      bval_reg;
    logic                               imp_reg;
    logic                               mstart;
    logic [63:0]                        ma;
    logic [63:0]                        mb;
    logic                               mdone;
    logic [127:0]                       mprod;
    logic [rfbfs_pkg::RID_W-1:0]        ri;
    logic                               improve;
    logic                               load_out;

    assign ri = r_reg[rfbfs_pkg::RID_W-1:0];

    rfbfs_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mstart),
        .a       (ma),
        .b       (mb),
        .done    (mdone),
        .product (mprod)
    );

    always_comb
    begin
        st_next   = st_reg;
        pst_next  = pst_reg;
        busy_next = busy_reg;
        r_next    = r_reg;
        mstart    = 1'b0;
        ma        = '0;
        mb        = '0;
        job_pop   = 1'b0;
        rd_en     = 1'b0;
        rd_region = ri;
        improve   = 1'b0;
        load_out  = 1'b0;
        case (st_reg)
            rfbfs_pkg::BK_IDLE:
            begin
                if (job_avail)
                begin
                    r_next  = '0;
                    rd_en   = 1'b1;
                    rd_region = '0;
                    st_next = rfbfs_pkg::BK_PREP;
                    pst_next = rfbfs_pkg::MUL_NQ;
                    busy_next = 1'b0;
                end
            end
            rfbfs_pkg::BK_PREP:
            begin
                if (!busy_reg)
                begin
                    if (rd_n == '0)
                    begin
                        st_next = rfbfs_pkg::BK_OUT;
                    end
                    else
                    begin
                        mstart = 1'b1;
                        busy_next = 1'b1;
                        case (pst_reg)
                            rfbfs_pkg::MUL_NQ:
                            begin
                                ma = 64'(rd_n);
                                mb = 64'(rd_q);
                            end
                            rfbfs_pkg::MUL_SS:
                            begin
                                ma = 64'(rd_s);
                                mb = 64'(rd_s);
                            end
                            default:
                            begin
                                ma = 64'(rd_n);
                                mb = 64'(rd_s);
                            end
                        endcase
                    end
                end
                else if (mdone)
                begin
                    busy_next = 1'b0;
                    case (pst_reg)
                        rfbfs_pkg::MUL_NQ: pst_next = rfbfs_pkg::MUL_SS;
                        rfbfs_pkg::MUL_SS: pst_next = rfbfs_pkg::MUL_NS;
                        default:           st_next  = rfbfs_pkg::BK_MULA;
                    endcase
                end
            end
            rfbfs_pkg::BK_MULA:
            begin
                if (!busy_reg)
                begin
                    mstart = 1'b1;
                    busy_next = 1'b1;
                    ma = num_reg;
                    mb = 64'(bden_reg[ri]);
                end
                else if (mdone)
                begin
                    busy_next = 1'b0;
                    st_next = rfbfs_pkg::BK_MULB;
                end
            end
            rfbfs_pkg::BK_MULB:
            begin
                if (!busy_reg)
                begin
                    mstart = 1'b1;
                    busy_next = 1'b1;
                    ma = 64'(bnum_reg[ri]);
                    mb = den_reg;
                end
                else if (mdone)
                begin
                    busy_next = 1'b0;
                    st_next = rfbfs_pkg::BK_CMP;
                end
            end
            rfbfs_pkg::BK_CMP:
            begin
                improve = lhs_reg > mprod;
                st_next = rfbfs_pkg::BK_OUT;
            end
            rfbfs_pkg::BK_OUT:
            begin
                if (!out_valid || !out_stall)
                begin
                    load_out = 1'b1;
                    if (r_reg + 1'b1 == cur_reg.n_out)
                    begin
                        job_pop = 1'b1;
                        st_next = rfbfs_pkg::BK_IDLE;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                        rd_en = 1'b1;
                        rd_region = ri + 1'b1;
                        pst_next = rfbfs_pkg::MUL_NQ;
                        st_next = rfbfs_pkg::BK_PREP;
                    end
                end
            end
            default:
            begin
                st_next = rfbfs_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= rfbfs_pkg::BK_IDLE;
            pst_reg   <= rfbfs_pkg::MUL_NQ;
            busy_reg  <= 1'b0;
            r_reg     <= '0;
            bval_reg  <= '0;
            out_valid <= 1'b0;
            imp_reg   <= 1'b0;
            for (int i = 0; i < NR; i++)
            begin
                bnum_reg[i] <= '0;
                bden_reg[i] <= (2*PIXEL_COUNT_BITS+8)'(1);
                bfr_reg[i]  <= '0;
            end
        end
        else
        begin
            st_reg   <= st_next;
            pst_reg  <= pst_next;
            busy_reg <= busy_next;
            r_reg    <= r_next;
            if (st_reg == rfbfs_pkg::BK_CMP)
            begin
                imp_reg <= improve;
                if (improve)
                begin
                    bnum_reg[ri] <= num_reg[61:0];
                    bden_reg[ri] <= den_reg[2*PIXEL_COUNT_BITS+7:0];
                    bfr_reg[ri]  <= FRAME_BITS'(cur_reg.frame);
                    bval_reg[ri] <= 1'b1;
                end
            end
            else if (st_reg == rfbfs_pkg::BK_PREP && !busy_reg && rd_n == '0)
            begin
                imp_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == rfbfs_pkg::BK_IDLE && job_avail)
        begin
            cur_reg <= job;
        end
        if (st_reg == rfbfs_pkg::BK_PREP && busy_reg && mdone)
        begin
            case (pst_reg)
                rfbfs_pkg::MUL_NQ: nq_reg  <= mprod[63:0];
                rfbfs_pkg::MUL_SS: num_reg <= nq_reg - mprod[63:0];
                default:           den_reg <= mprod[63:0];
            endcase
        end
        if (st_reg == rfbfs_pkg::BK_MULA && busy_reg && mdone)
        begin
            lhs_reg <= mprod;
        end
        if (load_out)
        begin
            region_index <= ri;
            best_frame   <= 16'(bfr_reg[ri]);
            best_found   <= bval_reg[ri];
            improved_now <= imp_reg;
            last_region  <= r_reg + 1'b1 == cur_reg.n_out;
        end
    end

`ifndef ASSERT_OFF
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(region_index))
        else $error("result dropped");
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> r_reg + 1'b1 == cur_reg.n_out)
        else $error("pop before last region");
    a_region_bound: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg != rfbfs_pkg::BK_IDLE |-> r_reg < cur_reg.n_out)
        else $error("region index overrun");
`endif

endmodule

// ===== src/region_focus_best_frame_select_core.sv =====
// scoring: after a frame's last pixel, each region in use is scored in turn;
// a nonempty region takes five 64x64 products on one 32x32 multiplier, an
// empty region skips them; either can be held by an output stall
// pixel throughput: one per cycle; a frame end stalls only while the previous
// frame's region results are still being scored or waiting to be taken
// reset: asynchronous active low; clears counts, bests, frame number, regions_in_use to 16
module region_focus_best_frame_select_core
#(
    parameter int MAX_REGIONS      = rfbfs_pkg::MAX_REGIONS_DEF,
    parameter int PIXEL_COUNT_BITS = rfbfs_pkg::PIXEL_COUNT_BITS_DEF,
    parameter int FRAME_BITS       = rfbfs_pkg::FRAME_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [rfbfs_pkg::PIX_W-1:0]      gray_pixel,
    input  logic [rfbfs_pkg::RID_W-1:0]      region_id,
    input  logic                             in_region,
    input  logic                             end_of_frame,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rfbfs_pkg::RID_W-1:0]      region_index,
    output logic [15:0]                      best_frame,
    output logic                             best_found,
    output logic                             improved_now,
    output logic                             last_region,
    input  logic                             cfg_we,
    input  logic [rfbfs_pkg::CFG_W-1:0]      cfg_wdata
);

    logic [rfbfs_pkg::CFG_W-1:0]    regions_in_use_reg;
    logic                           rd_en;
    logic [rfbfs_pkg::RID_W-1:0]    rd_region;
    logic [PIXEL_COUNT_BITS-1:0]    rd_n;
    logic [PIXEL_COUNT_BITS+7:0]    rd_s;
    logic [PIXEL_COUNT_BITS+15:0]   rd_q;
    logic                           job_pop;
    logic                           job_avail;
    rfbfs_pkg::frame_job_t          job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regions_in_use_reg <= rfbfs_pkg::REGIONS_RESET;
        end
        else if (cfg_we)
        begin
            regions_in_use_reg <= cfg_wdata;
        end
    end

    rfbfs_front
    #(
        .MAX_REGIONS      (MAX_REGIONS),
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .FRAME_BITS       (FRAME_BITS)
    )
    u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .gray_pixel   (gray_pixel),
        .region_id    (region_id),
        .in_region    (in_region),
        .end_of_frame (end_of_frame),
        .regions_cfg  (regions_in_use_reg),
        .rd_en        (rd_en),
        .rd_region    (rd_region),
        .rd_n         (rd_n),
        .rd_s         (rd_s),
        .rd_q         (rd_q),
        .job_pop      (job_pop),
        .job_avail    (job_avail),
        .job          (job)
    );

    rfbfs_back
    #(
        .PIXEL_COUNT_BITS (PIXEL_COUNT_BITS),
        .FRAME_BITS       (FRAME_BITS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (job_avail),
        .job          (job),
        .job_pop      (job_pop),
        .rd_en        (rd_en),
        .rd_region    (rd_region),
        .rd_n         (rd_n),
        .rd_s         (rd_s),
        .rd_q         (rd_q),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .region_index (region_index),
        .best_frame   (best_frame),
        .best_found   (best_found),
        .improved_now (improved_now),
        .last_region  (last_region)
    );

endmodule

// ===== tb/sv/region_focus_best_frame_select_core_tb.sv =====
`timescale 1ns / 100ps

module region_focus_best_frame_select_core_tb;

    localparam int NREG = rfbfs_pkg::HW_REGIONS;
    localparam logic [22:0] COUNT_CAP = 23'h7FFFFF;

    typedef struct packed {
        logic [7:0] pix;
        logic [3:0] rid;
        logic       inr;
        logic       eof;
    } pixel_word_t;

    typedef struct packed {
        logic [3:0]  idx;
        logic [15:0] frame;
        logic        found;
        logic        improved;
        logic        last;
    } region_report_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [7:0] gray_pixel;
    logic [3:0] region_id;
    logic in_region;
    logic end_of_frame;
    logic out_valid;
    logic out_stall;
    logic [3:0] region_index;
    logic [15:0] best_frame;
    logic best_found;
    logic improved_now;
    logic last_region;
    logic cfg_we;
    logic [4:0] cfg_wdata;

    pixel_word_t pending_pixels[$];
    region_report_t expected_reports[$];
    int errors;
    int pixel_gap;
    int stall_len;
    bit stall_phase;
    bit in_accepted;

    logic [4:0]   regions_cfg;
    logic [63:0]  acc_n[NREG];
    logic [63:0]  acc_s[NREG];
    logic [63:0]  acc_q[NREG];
    logic [63:0]  top_num[NREG];
    logic [63:0]  top_den[NREG];
    logic [15:0]  top_frame[NREG];
    logic         top_valid[NREG];
    logic [15:0]  frame_no;

    region_focus_best_frame_select_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .gray_pixel(gray_pixel), .region_id(region_id),
        .in_region(in_region), .end_of_frame(end_of_frame),
        .out_valid(out_valid), .out_stall(out_stall),
        .region_index(region_index), .best_frame(best_frame),
        .best_found(best_found), .improved_now(improved_now),
        .last_region(last_region),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    task automatic clear_frame_sums();
        for (int r = 0; r < NREG; r++)
        begin
            acc_n[r] = '0;
            acc_s[r] = '0;
            acc_q[r] = '0;
        end
    endtask

    task automatic reset_focus_state();
        regions_cfg = rfbfs_pkg::REGIONS_RESET;
        clear_frame_sums();
        for (int r = 0; r < NREG; r++)
        begin
            top_num[r] = '0;
            top_den[r] = 64'd1;
            top_frame[r] = '0;
            top_valid[r] = 1'b0;
        end
        frame_no = '0;
    endtask

    task automatic score_pixel(input pixel_word_t w);
        int n_out;
        logic [63:0] num;
        logic [63:0] den;
        logic [127:0] lhs;
        logic [127:0] rhs;
        region_report_t rep;
        if (w.inr && w.pix != 0 && acc_n[w.rid] < COUNT_CAP)
        begin
            acc_n[w.rid] += 1;
            acc_s[w.rid] += w.pix;
            acc_q[w.rid] += w.pix * w.pix;
        end
        if (!w.eof)
            return;
        n_out = regions_cfg;
        if (n_out == 0)
            n_out = 1;
        if (n_out > NREG)
            n_out = NREG;
        for (int r = 0; r < n_out; r++)
        begin
            rep.improved = 1'b0;
            if (acc_n[r] != 0)
            begin
                num = acc_n[r] * acc_q[r] - acc_s[r] * acc_s[r];
                den = acc_n[r] * acc_s[r];
                lhs = 128'(num) * 128'(top_den[r]);
                rhs = 128'(top_num[r]) * 128'(den);
                if (lhs > rhs)
                begin
                    top_num[r] = num;
                    top_den[r] = den;
                    top_frame[r] = frame_no;
                    top_valid[r] = 1'b1;
                    rep.improved = 1'b1;
                end
            end
            rep.idx = r[3:0];
            rep.frame = top_frame[r];
            rep.found = top_valid[r];
            rep.last = (r + 1 == n_out);
            expected_reports.push_back(rep);
        end
        clear_frame_sums();
        frame_no += 1;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel_gap <= 0;
        end
        else if (!in_valid || in_accepted)
        begin
            if (pixel_gap > 0 || pending_pixels.size() == 0)
            begin
                in_valid <= 1'b0;
                if (pixel_gap > 0)
                    pixel_gap <= pixel_gap - 1;
            end
            else
            begin
                pixel_word_t w;
                w = pending_pixels.pop_front();
                gray_pixel <= w.pix;
                region_id <= w.rid;
                in_region <= w.inr;
                end_of_frame <= w.eof;
                in_valid <= 1'b1;
                if ($urandom_range(0, 2) != 0)
                    pixel_gap <= pick_gap();
            end
        end
    end

    // output stall pattern
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_len <= 0;
            stall_phase <= 1'b0;
        end
        else if (stall_len > 0)
            stall_len <= stall_len - 1;
        else
        begin
            stall_phase <= ~stall_phase;
            out_stall <= ~stall_phase;
            stall_len <= stall_phase ? $urandom_range(0, 30) : pick_gap();
        end
    end

    // prediction on accepted input words
    always @(posedge clk)
    begin
        in_accepted = rst_n && in_valid && !in_stall;
        if (in_accepted)
            score_pixel('{gray_pixel, region_id, in_region, end_of_frame});
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                $display("%0t: unexpected result region %0d", $time, region_index);
                errors++;
            end
            else
            begin
                region_report_t e;
                e = expected_reports.pop_front();
                if (e !== {region_index, best_frame, best_found, improved_now, last_region})
                begin
                    $display("%0t: mismatch exp idx=%0d frame=%0d found=%0b imp=%0b last=%0b",
                        $time, e.idx, e.frame, e.found, e.improved, e.last);
                    $display("%0t:          got idx=%0d frame=%0d found=%0b imp=%0b last=%0b",
                        $time, region_index, best_frame, best_found, improved_now,
                        last_region);
                    errors++;
                end
            end
        end
    end

    task automatic add_pixel(input int pix, input int rid, input bit inr, input bit eof);
        pixel_word_t w;
        w.pix = pix[7:0];
        w.rid = rid[3:0];
        w.inr = inr;
        w.eof = eof;
        pending_pixels.push_back(w);
    endtask

    task automatic drain();
        while (pending_pixels.size() != 0 || in_valid || expected_reports.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_regions(input int v);
        @(negedge clk);
        cfg_wdata <= v[4:0];
        cfg_we <= 1'b1;
        @(posedge clk);
        regions_cfg = v[4:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_frames(input int frames);
        int len;
        for (int f = 0; f < frames; f++)
        begin
            len = $urandom_range(1, 9);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    add_pixel($urandom_range(0, 255), $urandom_range(0, 15),
                        $urandom_range(0, 1), i == len - 1);
                else
                    add_pixel($urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
                        : $urandom_range(100, 140), $urandom_range(0, 3),
                        1'b1, i == len - 1);
            end
        end
    endtask

    initial
    begin
        errors = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        gray_pixel = '0;
        region_id = '0;
        in_region = 1'b0;
        end_of_frame = 1'b0;
        reset_focus_state();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, ignored words, equal pixels, empty regions
        add_pixel(255, 0, 1, 0);
        add_pixel(1, 0, 1, 0);
        add_pixel(0, 1, 1, 0);
        add_pixel(200, 15, 1, 0);
        add_pixel(50, 15, 1, 0);
        add_pixel(77, 2, 0, 0);
        add_pixel(9, 3, 1, 0);
        add_pixel(9, 3, 1, 1);
        add_pixel(128, 0, 1, 0);
        add_pixel(127, 0, 1, 1);
        add_pixel(255, 0, 1, 0);
        add_pixel(1, 0, 1, 1);
        add_pixel(0, 0, 0, 1);
        drain();

        write_regions(0);
        add_pixel(10, 0, 1, 0);
        add_pixel(250, 0, 1, 1);
        add_pixel(5, 1, 1, 1);
        drain();
        write_regions(31);
        add_pixel(170, 10, 1, 0);
        add_pixel(85, 10, 1, 1);
        drain();
        write_regions(1);
        random_frames(6);
        drain();
        write_regions(4);
        random_frames(12);
        drain();
        write_regions(17);
        random_frames(4);
        drain();
        write_regions(16);
        random_frames(8);
        drain();

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
